// File: rtl/ppp_pkg.sv
// Shared types, constants and the divider step function for the point projector.
`default_nettype none

package ppp_pkg;

  // Matrix rows held in configuration and the two screen axes.
  localparam int unsigned NumRows  = 3;
  localparam int unsigned RowX     = 0;
  localparam int unsigned RowY     = 1;
  localparam int unsigned RowW     = 2;
  localparam int unsigned NumLanes = 2;
  localparam int unsigned LaneX    = 0;
  localparam int unsigned LaneY    = 1;

  // Field and register widths.
  localparam int unsigned WordBits = 32;
  localparam int unsigned CoefBits = 64;
  localparam int unsigned SizeBits = 14;
  localparam int unsigned IdxBits  = 3;

  // Divider geometry: a 32-bit quotient against a 33-bit divisor (twice W).
  localparam int unsigned QuoBits          = 32;
  localparam int unsigned DenBits          = 33;
  localparam int unsigned DivStepsPerStage = 2;
  localparam int unsigned DivStages        = QuoBits / DivStepsPerStage;

  // Pipeline depth of each section.
  localparam int unsigned XformStages = 3;
  localparam int unsigned ScaleStages = 4;
  localparam int unsigned OutStages   = 1;

  localparam logic [SizeBits-1:0] ResetWidth  = 14'd1920;
  localparam logic [SizeBits-1:0] ResetHeight = 14'd1080;

  localparam logic [WordBits-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [WordBits-1:0] SatMin = 32'h8000_0000;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [CoefBits-1:0] coef_t;
  typedef logic [SizeBits-1:0] size_t;
  typedef logic [DenBits-1:0]  den_t;
  typedef logic [QuoBits-1:0]  quo_t;

  // Configuration register indexes.
  typedef enum logic [IdxBits-1:0] {
    RegRowXLow      = 3'd0,
    RegRowXHigh     = 3'd1,
    RegRowYLow      = 3'd2,
    RegRowYHigh     = 3'd3,
    RegRowWLow      = 3'd4,
    RegRowWHigh     = 3'd5,
    RegScreenWidth  = 3'd6,
    RegScreenHeight = 3'd7
  } reg_e;

  // Control that travels with a transaction through the divider.
  typedef struct packed {
    logic                valid;
    logic                front;
    logic [NumLanes-1:0] sat_lo;
    logic [NumLanes-1:0] sat_hi;
  } ctl_t;

  // Partial remainder and the dividend word that turns into the quotient.
  typedef struct packed {
    den_t rem;
    quo_t dvd;
  } div_state_t;

  // One restoring division step: bring in the next dividend bit, subtract if it fits.
  function automatic div_state_t div_step(den_t rem, quo_t dvd, den_t den);
    logic [DenBits:0] trial;
    logic [DenBits:0] diff;
    div_state_t       res;
    trial = {rem, dvd[QuoBits-1]};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      res.rem = diff[DenBits-1:0];
      res.dvd = {dvd[QuoBits-2:0], 1'b1};
    end else begin
      res.rem = trial[DenBits-1:0];
      res.dvd = {dvd[QuoBits-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/perspective_point_projector_core.sv
// A point taken with start passes through 3 transform stages, 4 scaling stages,
// 16 divider stages and 1 output register before its result is strobed on done_o.
// Throughput: one point per clock cycle; busy stays low, the pipeline never holds.
// The depth is set by the restoring divider, which retires two quotient bits a stage.
// Reset clears the valid bits and returns the matrix rows to zero and the viewport to
// 1920 by 1080; results are strobed for one cycle and cannot be held off.
`default_nettype none

module perspective_point_projector_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [ppp_pkg::WordBits-1:0]  pos_x_i,
  input  wire logic signed [ppp_pkg::WordBits-1:0]  pos_y_i,
  input  wire logic signed [ppp_pkg::WordBits-1:0]  pos_z_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [ppp_pkg::IdxBits-1:0]          cfg_idx_i,
  input  wire logic [ppp_pkg::CoefBits-1:0]         cfg_wdata_i,
  output logic                                      done_o,
  output logic                                      in_front_o,
  output logic signed [ppp_pkg::WordBits-1:0]       screen_x_o,
  output logic signed [ppp_pkg::WordBits-1:0]       screen_y_o
);

  localparam int unsigned Latency = ppp_pkg::XformStages + ppp_pkg::ScaleStages
                                  + ppp_pkg::DivStages + ppp_pkg::OutStages;

  ppp_pkg::coef_t [ppp_pkg::NumRows-1:0]   row_lo_d, row_lo_q;
  ppp_pkg::coef_t [ppp_pkg::NumRows-1:0]   row_hi_d, row_hi_q;
  ppp_pkg::size_t                          width_d, width_q;
  ppp_pkg::size_t                          height_d, height_q;
  logic                                    accept;
  logic                                    xf_valid;
  ppp_pkg::word_t [ppp_pkg::NumRows-1:0]   row_val;
  ppp_pkg::ctl_t                           sc_ctl;
  ppp_pkg::den_t [ppp_pkg::NumLanes-1:0]   sc_rem;
  ppp_pkg::quo_t [ppp_pkg::NumLanes-1:0]   sc_dvd;
  ppp_pkg::den_t                           sc_den;

  // The pipeline takes a transaction every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration register writes.
  always_comb begin
    row_lo_d = row_lo_q;
    row_hi_d = row_hi_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (ppp_pkg::reg_e'(cfg_idx_i))
        ppp_pkg::RegRowXLow:      row_lo_d[ppp_pkg::RowX] = cfg_wdata_i;
        ppp_pkg::RegRowXHigh:     row_hi_d[ppp_pkg::RowX] = cfg_wdata_i;
        ppp_pkg::RegRowYLow:      row_lo_d[ppp_pkg::RowY] = cfg_wdata_i;
        ppp_pkg::RegRowYHigh:     row_hi_d[ppp_pkg::RowY] = cfg_wdata_i;
        ppp_pkg::RegRowWLow:      row_lo_d[ppp_pkg::RowW] = cfg_wdata_i;
        ppp_pkg::RegRowWHigh:     row_hi_d[ppp_pkg::RowW] = cfg_wdata_i;
        ppp_pkg::RegScreenWidth:  width_d  = cfg_wdata_i[ppp_pkg::SizeBits-1:0];
        ppp_pkg::RegScreenHeight: height_d = cfg_wdata_i[ppp_pkg::SizeBits-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_lo_q <= '0;
      row_hi_q <= '0;
      width_q  <= ppp_pkg::ResetWidth;
      height_q <= ppp_pkg::ResetHeight;
    end else begin
      row_lo_q <= row_lo_d;
      row_hi_q <= row_hi_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Matrix rows applied to the point.
  ppp_xform #(
    .FRAC_BITS (FRAC_BITS)
  ) u_xform (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .pos_x_i   (pos_x_i),
    .pos_y_i   (pos_y_i),
    .pos_z_i   (pos_z_i),
    .row_lo_i  (row_lo_q),
    .row_hi_i  (row_hi_q),
    .valid_o   (xf_valid),
    .row_val_o (row_val)
  );

  // Viewport scaling and dividend preparation.
  ppp_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (xf_valid),
    .row_val_i       (row_val),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .ctl_o           (sc_ctl),
    .rem_o           (sc_rem),
    .dvd_o           (sc_dvd),
    .den_o           (sc_den)
  );

  // Perspective divide and output register.
  ppp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sc_ctl),
    .rem_i      (sc_rem),
    .dvd_i      (sc_dvd),
    .den_i      (sc_den),
    .done_o     (done_o),
    .in_front_o (in_front_o),
    .screen_x_o (screen_x_o),
    .screen_y_o (screen_y_o)
  );

  // Every accepted transaction produces its result after the fixed latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("result strobe missing after the pipeline latency");

  // A point behind the camera reports zero coordinates.
  a_behind_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !in_front_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("non-zero coordinates for a point behind the camera");

  // The in-front flag is only raised together with the result strobe.
  a_front_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_front_o |-> done_o)
    else $error("in-front flag raised without a result");

endmodule

`default_nettype wire

// File: rtl/ppp_xform.sv
// Three-stage matrix row transform producing saturated X, Y and W.
`default_nettype none

module ppp_xform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       valid_i,
  input  wire logic signed [ppp_pkg::WordBits-1:0]        pos_x_i,
  input  wire logic signed [ppp_pkg::WordBits-1:0]        pos_y_i,
  input  wire logic signed [ppp_pkg::WordBits-1:0]        pos_z_i,
  input  wire ppp_pkg::coef_t [ppp_pkg::NumRows-1:0]      row_lo_i,
  input  wire ppp_pkg::coef_t [ppp_pkg::NumRows-1:0]      row_hi_i,
  output logic                                            valid_o,
  output ppp_pkg::word_t [ppp_pkg::NumRows-1:0]           row_val_o
);

  localparam int unsigned Rows    = ppp_pkg::NumRows;
  localparam int unsigned WB      = ppp_pkg::WordBits;
  localparam int unsigned ProdB   = 2 * WB;
  localparam int unsigned SumB    = ProdB + 2;
  localparam int unsigned TotalB  = SumB + 1;

  logic [Rows-1:0][2:0][ProdB-1:0] prod_d, prod_q;
  logic [Rows-1:0][WB-1:0]         trans1_q, trans2_q;
  logic [Rows-1:0][SumB-1:0]       sum_d, sum_q;
  logic [Rows-1:0][SumB-1:0]       shift_s;
  logic [Rows-1:0][TotalB-1:0]     total_s;
  logic [Rows-1:0][WB-1:0]         val_d, val_q;
  logic                            v1_q, v2_q, v3_q;

  // Stage one: the nine exact coefficient products.
  always_comb begin
    for (int r = 0; r < Rows; r++) begin
      prod_d[r][0] = $signed(row_lo_i[r][WB-1:0]) * pos_x_i;
      prod_d[r][1] = $signed(row_lo_i[r][2*WB-1:WB]) * pos_y_i;
      prod_d[r][2] = $signed(row_hi_i[r][WB-1:0]) * pos_z_i;
    end
  end

  // Stage two: sum the three products of each row at full precision.
  always_comb begin
    for (int r = 0; r < Rows; r++) begin
      sum_d[r] = {{2{prod_q[r][0][ProdB-1]}}, prod_q[r][0]}
               + {{2{prod_q[r][1][ProdB-1]}}, prod_q[r][1]}
               + {{2{prod_q[r][2][ProdB-1]}}, prod_q[r][2]};
    end
  end

  // Stage three: floor to the fixed-point grid, add the translation and saturate.
  always_comb begin
    for (int r = 0; r < Rows; r++) begin
      shift_s[r] = SumB'($signed(sum_q[r]) >>> FRAC_BITS);
      total_s[r] = {shift_s[r][SumB-1], shift_s[r]}
                 + {{(TotalB-WB){trans2_q[r][WB-1]}}, trans2_q[r]};
      priority if (!total_s[r][TotalB-1] && (|total_s[r][TotalB-2:WB-1])) begin
        val_d[r] = ppp_pkg::SatMax;
      end else if (total_s[r][TotalB-1] && !(&total_s[r][TotalB-2:WB-1])) begin
        val_d[r] = ppp_pkg::SatMin;
      end else begin
        val_d[r] = total_s[r][WB-1:0];
      end
    end
  end

  // Data registers of the three stages.
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    sum_q   <= sum_d;
    val_q   <= val_d;
    for (int r = 0; r < Rows; r++) begin
      trans1_q[r] <= row_hi_i[r][2*WB-1:WB];
    end
    trans2_q <= trans1_q;
  end

  // Valid bits that travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o   = v3_q;
  assign row_val_o = val_q;

endmodule

`default_nettype wire

// File: rtl/ppp_scale.sv
// Four-stage viewport scaling that prepares the offset dividend for the divider.
`default_nettype none

module ppp_scale #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       valid_i,
  input  wire ppp_pkg::word_t [ppp_pkg::NumRows-1:0]      row_val_i,
  input  wire ppp_pkg::size_t                             screen_width_i,
  input  wire ppp_pkg::size_t                             screen_height_i,
  output ppp_pkg::ctl_t                                   ctl_o,
  output ppp_pkg::den_t [ppp_pkg::NumLanes-1:0]           rem_o,
  output ppp_pkg::quo_t [ppp_pkg::NumLanes-1:0]           dvd_o,
  output ppp_pkg::den_t                                   den_o
);

  localparam int unsigned Lanes    = ppp_pkg::NumLanes;
  localparam int unsigned WB       = ppp_pkg::WordBits;
  localparam int unsigned QB       = ppp_pkg::QuoBits;
  localparam int unsigned DB       = ppp_pkg::DenBits;
  localparam int unsigned NumB     = WB + 2;
  localparam int unsigned ProdB    = NumB + ppp_pkg::SizeBits + 1;
  localparam int unsigned ShiftedB = ProdB + FRAC_BITS;
  localparam int unsigned BigB     = ((ShiftedB > 2 * WB) ? ShiftedB : 2 * WB) + 2;
  localparam int unsigned TopB     = BigB - QB;

  // Near threshold, 0.0001 rounded to the nearest step and at least one step.
  localparam longint NearRaw = ((longint'(1) << FRAC_BITS) + 5000) / 10000;
  localparam logic [WB-1:0] NearMin = (NearRaw > 0) ? WB'(NearRaw) : WB'(1);

  logic [Lanes-1:0][NumB-1:0]                num_d, num_q;
  logic [Lanes-1:0][ppp_pkg::SizeBits-1:0]   size_s;
  logic [Lanes-1:0][ProdB-1:0]               prod_d, prod_q;
  logic [Lanes-1:0][BigB-1:0]                big_d, big_q;
  ppp_pkg::den_t                             den1_q, den2_q, den3_q, den4_q;
  logic                                      front_d;
  logic                                      v1_q, v2_q, v3_q;
  logic                                      f1_q, f2_q, f3_q;
  ppp_pkg::ctl_t                             ctl_d, ctl_q;
  ppp_pkg::den_t [Lanes-1:0]                 rem_d, rem_q;
  ppp_pkg::quo_t [Lanes-1:0]                 dvd_d, dvd_q;

  // Stage one: numerator terms W+X and W-Y, near test and divisor 2W.
  always_comb begin
    num_d[ppp_pkg::LaneX] = {{2{row_val_i[ppp_pkg::RowW][WB-1]}}, row_val_i[ppp_pkg::RowW]}
                          + {{2{row_val_i[ppp_pkg::RowX][WB-1]}}, row_val_i[ppp_pkg::RowX]};
    num_d[ppp_pkg::LaneY] = {{2{row_val_i[ppp_pkg::RowW][WB-1]}}, row_val_i[ppp_pkg::RowW]}
                          - {{2{row_val_i[ppp_pkg::RowY][WB-1]}}, row_val_i[ppp_pkg::RowY]};
    front_d = $signed(row_val_i[ppp_pkg::RowW]) >= $signed(NearMin);
  end

  // Stage two: scale each numerator by the viewport size.
  assign size_s[ppp_pkg::LaneX] = screen_width_i;
  assign size_s[ppp_pkg::LaneY] = screen_height_i;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      prod_d[l] = $signed({1'b0, size_s[l]}) * $signed(num_q[l]);
    end
  end

  // Stage three: shift to the fixed-point grid and add (2^31 + one half) times
  // the divisor, so that the quotient is the result offset by 2^31.
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      big_d[l] = (BigB'($signed(prod_q[l])) << FRAC_BITS)
               + (BigB'(den2_q) << (QB - 1))
               + (BigB'(den2_q) << (FRAC_BITS - 1));
    end
  end

  // Stage four: range checks and the initial partial remainder.
  always_comb begin
    ctl_d       = '0;
    ctl_d.valid = v3_q;
    ctl_d.front = f3_q;
    for (int l = 0; l < Lanes; l++) begin
      ctl_d.sat_lo[l] = big_q[l][BigB-1];
      ctl_d.sat_hi[l] = !big_q[l][BigB-1] && (big_q[l][BigB-1:QB] >= TopB'(den3_q));
      rem_d[l]        = big_q[l][QB+DB-1:QB];
      dvd_d[l]        = big_q[l][QB-1:0];
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den1_q <= {row_val_i[ppp_pkg::RowW], 1'b0};
    prod_q <= prod_d;
    den2_q <= den1_q;
    big_q  <= big_d;
    den3_q <= den2_q;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    den4_q <= den3_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      f1_q  <= 1'b0;
      f2_q  <= 1'b0;
      f3_q  <= 1'b0;
      ctl_q <= '0;
    end else begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      f1_q  <= front_d;
      f2_q  <= f1_q;
      f3_q  <= f2_q;
      ctl_q <= ctl_d;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign dvd_o = dvd_q;
  assign den_o = den4_q;

endmodule

`default_nettype wire

// File: rtl/ppp_div.sv
// Pipelined two-lane restoring divider with the saturating output register.
`default_nettype none

module ppp_div (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire ppp_pkg::ctl_t                          ctl_i,
  input  wire ppp_pkg::den_t [ppp_pkg::NumLanes-1:0]  rem_i,
  input  wire ppp_pkg::quo_t [ppp_pkg::NumLanes-1:0]  dvd_i,
  input  wire ppp_pkg::den_t                          den_i,
  output logic                                        done_o,
  output logic                                        in_front_o,
  output logic signed [ppp_pkg::WordBits-1:0]         screen_x_o,
  output logic signed [ppp_pkg::WordBits-1:0]         screen_y_o
);

  localparam int unsigned Lanes  = ppp_pkg::NumLanes;
  localparam int unsigned Stages = ppp_pkg::DivStages;
  localparam int unsigned QB     = ppp_pkg::QuoBits;

  ppp_pkg::ctl_t [Stages-1:0]                     ctl_q;
  ppp_pkg::den_t [Stages-1:0]                     den_q;
  ppp_pkg::den_t [Stages-1:0][Lanes-1:0]          rem_d, rem_q;
  ppp_pkg::quo_t [Stages-1:0][Lanes-1:0]          dvd_d, dvd_q;
  ppp_pkg::ctl_t                                  last_ctl;
  ppp_pkg::word_t [Lanes-1:0]                     scr_d, scr_q;
  logic                                           done_q, front_q;

  // Each stage retires two quotient bits per lane.
  for (genvar s = 0; s < Stages; s++) begin : g_stage
    ppp_pkg::ctl_t             ctl_in;
    ppp_pkg::den_t             den_in;
    ppp_pkg::den_t [Lanes-1:0] rem_in;
    ppp_pkg::quo_t [Lanes-1:0] dvd_in;

    if (s == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign den_in = den_i;
      assign rem_in = rem_i;
      assign dvd_in = dvd_i;
    end else begin : g_next
      assign ctl_in = ctl_q[s-1];
      assign den_in = den_q[s-1];
      assign rem_in = rem_q[s-1];
      assign dvd_in = dvd_q[s-1];
    end

    always_comb begin
      ppp_pkg::div_state_t st;
      for (int l = 0; l < Lanes; l++) begin
        st.rem = rem_in[l];
        st.dvd = dvd_in[l];
        for (int k = 0; k < ppp_pkg::DivStepsPerStage; k++) begin
          st = ppp_pkg::div_step(st.rem, st.dvd, den_in);
        end
        rem_d[s][l] = st.rem;
        dvd_d[s][l] = st.dvd;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s] <= den_in;
      rem_q[s] <= rem_d[s];
      dvd_q[s] <= dvd_d[s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end
  end

  // Output selection: behind the camera gives zero, out of range saturates,
  // otherwise the quotient less its 2^31 offset.
  assign last_ctl = ctl_q[Stages-1];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      priority if (!last_ctl.front) begin
        scr_d[l] = '0;
      end else if (last_ctl.sat_lo[l]) begin
        scr_d[l] = ppp_pkg::SatMin;
      end else if (last_ctl.sat_hi[l]) begin
        scr_d[l] = ppp_pkg::SatMax;
      end else begin
        scr_d[l] = {~dvd_q[Stages-1][l][QB-1], dvd_q[Stages-1][l][QB-2:0]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scr_q <= scr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      front_q <= 1'b0;
    end else begin
      done_q  <= last_ctl.valid;
      front_q <= last_ctl.valid && last_ctl.front;
    end
  end

  assign done_o     = done_q;
  assign in_front_o = front_q;
  assign screen_x_o = scr_q[ppp_pkg::LaneX];
  assign screen_y_o = scr_q[ppp_pkg::LaneY];

endmodule

`default_nettype wire
